[hdl/uie_pkg.sv]
// Shared types, widths and constants of the unit interval estimator.
`default_nettype none
package uie_pkg;

    localparam int unsigned SpanW = 64;
    localparam int unsigned NumW  = 72;
    localparam int unsigned CntW  = 17;
    localparam int unsigned IvlW  = 23;
    localparam int unsigned NomW  = 24;
    localparam int unsigned DenW  = 40;
    localparam int unsigned EstW  = 47;
    localparam int unsigned LimW  = 63;
    localparam int unsigned UiW   = 21;

    localparam int unsigned DivSteps      = 21;
    localparam int unsigned StepsPerStage = 2;
    localparam int unsigned DivStages     = (DivSteps + StepsPerStage - 1) / StepsPerStage;

    localparam logic [SpanW-1:0] TIME_WRAP = 64'd65536000000000;
    localparam logic [CntW-1:0]  CNT_WRAP  = 17'd65536;
    localparam logic [IvlW-1:0]  IVL_LONG  = 23'd5406720;
    localparam logic [IvlW-1:0]  IVL_SHORT = 23'd6336;
    localparam logic [15:0]      EST_MUL   = 16'd64001;

    localparam logic [UiW-1:0] WIN25_HI = 21'h09EE42;
    localparam logic [UiW-1:0] WIN25_LO = 21'h09EDC0;
    localparam logic [UiW-1:0] WIN10_HI = 21'h18D3A4;
    localparam logic [UiW-1:0] WIN10_LO = 21'h18D25F;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DISABLED = 3'd1;
    localparam logic [2:0] ST_TOO_SLOW = 3'd2;
    localparam logic [2:0] ST_TX_EST   = 3'd3;
    localparam logic [2:0] ST_RX_EST   = 3'd4;
    localparam logic [2:0] ST_TX_WIN   = 3'd5;
    localparam logic [2:0] ST_RX_WIN   = 3'd6;

    localparam logic [2:0] REG_ADJUST   = 3'd0;
    localparam logic [2:0] REG_FEC      = 3'd1;
    localparam logic [2:0] REG_LANE     = 3'd2;
    localparam logic [2:0] REG_NOM_10G  = 3'd3;
    localparam logic [2:0] REG_NOM_25G  = 3'd4;
    localparam logic [2:0] REG_SPEED25  = 3'd5;

    localparam logic [1:0] FEC_KR   = 2'd0;
    localparam logic [1:0] FEC_NONE = 2'd1;
    localparam logic [1:0] LANE_10G = 2'd0;
    localparam logic [1:0] LANE_25G = 2'd1;

    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [DenW-1:0] den;
        logic [UiW-1:0]  quo;
    } t_div;

    typedef struct packed {
        logic       done;
        logic [2:0] code;
    } t_ctl;

endpackage
`default_nettype wire

[hdl/uie_span.sv]
// Wrapped time delta and marker counter delta for one direction.
`default_nettype none
module uie_span (
    input  wire logic [uie_pkg::SpanW-1:0] i_time_first,
    input  wire logic [uie_pkg::SpanW-1:0] i_time_later,
    input  wire logic [15:0]               i_count_first,
    input  wire logic [15:0]               i_count_later,
    output logic [uie_pkg::SpanW-1:0]      o_span,
    output logic [uie_pkg::CntW-1:0]       o_cnt
);
    logic [uie_pkg::CntW-1:0] w_cf;
    logic [uie_pkg::CntW-1:0] w_cl;

    assign w_cf = {1'b0, i_count_first};
    assign w_cl = {1'b0, i_count_later};

    always_comb begin
        if (i_time_later <= i_time_first) begin
            o_span = i_time_later + uie_pkg::TIME_WRAP - i_time_first;
        end else begin
            o_span = i_time_later - i_time_first;
        end
        if (w_cl <= w_cf) begin
            o_cnt = w_cl + uie_pkg::CNT_WRAP - w_cf;
        end else begin
            o_cnt = w_cl - w_cf;
        end
    end
endmodule
`default_nettype wire

[hdl/uie_div_stage.sv]
// Restoring division slice: NUM_STEPS quotient bits per pipeline stage.
`default_nettype none
module uie_div_stage #(
    parameter int unsigned FIRST_STEP = 20,
    parameter int unsigned NUM_STEPS  = 2
) (
    input  wire uie_pkg::t_div i_d,
    output uie_pkg::t_div      o_d
);
    always_comb begin
        logic [uie_pkg::NumW-1:0] r;
        logic [uie_pkg::NumW-1:0] sh;
        logic [uie_pkg::UiW-1:0]  q;
        r = i_d.rem;
        q = i_d.quo;
        sh = '0;
        for (int k = 0; k < NUM_STEPS; k++) begin
            sh = {{(uie_pkg::NumW-uie_pkg::DenW){1'b0}}, i_d.den} << (FIRST_STEP - k);
            if (r >= sh) begin
                r = r - sh;
                q[FIRST_STEP - k] = 1'b1;
            end
        end
        o_d.rem = r;
        o_d.den = i_d.den;
        o_d.quo = q;
    end
endmodule
`default_nettype wire

[hdl/unit_interval_estimator_unit.sv]
// Top level of the unit interval estimator: config port and pipeline.
`default_nettype none
// Usage:
//  Input channel (i_valid/o_ready) takes one transaction of transmit and
//  receive snapshot pairs plus the too-slow flag. Output channel
//  (o_valid/i_ready) returns one transaction per input: both unit
//  intervals, the write flag and a status code.
//  Pipeline is 16 register stages: front end (deltas, products, estimate
//  limit, estimate compare), 11 restoring divider stages of two quotient
//  bits each (one in the last), and a window-check output register.
//  o_valid is driven by the valid bit of the last stage register, so the
//  result is registered; throughput is one transaction per cycle while
//  the receiver keeps i_ready high.
//  Each stage holds its item while the stage after it is full and not
//  advancing, so a receiver stall backs up only as far as the pipeline is
//  full; bubbles are squeezed out and nothing is lost or repeated.
//  Reset (i_rst_n low, synchronous) empties the pipeline and returns the
//  registers to their defaults. The user must write the APB-style port
//  only while the pipeline is empty (not enforced); pready is always high.
module unit_interval_estimator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_tx_time_first,
    input  wire logic [63:0] i_tx_time_later,
    input  wire logic [15:0] i_tx_count_first,
    input  wire logic [15:0] i_tx_count_later,
    input  wire logic [63:0] i_rx_time_first,
    input  wire logic [63:0] i_rx_time_later,
    input  wire logic [15:0] i_rx_count_first,
    input  wire logic [15:0] i_rx_count_later,
    input  wire logic        i_too_slow,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [20:0]      o_tx_unit_interval,
    output logic [20:0]      o_rx_unit_interval,
    output logic             o_write_values,
    output logic [2:0]       o_status
);
    localparam int unsigned DivN = uie_pkg::DivStages;
    localparam int unsigned NSt  = DivN + 5;   // four front, divider, output
    localparam int unsigned OutS = NSt - 1;

    // ---------------- configuration registers ----------------
    logic        r_adjust;
    logic [1:0]  r_fec;
    logic [1:0]  r_lane;
    logic [31:0] r_nom10;
    logic [31:0] r_nom25;
    logic        r_speed25;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust  <= 1'b1;
            r_fec     <= uie_pkg::FEC_KR;
            r_lane    <= uie_pkg::LANE_10G;
            r_nom10   <= 32'd1627904;
            r_nom25   <= 32'd650752;
            r_speed25 <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                uie_pkg::REG_ADJUST:  r_adjust  <= pwdata[0];
                uie_pkg::REG_FEC:     r_fec     <= pwdata[1:0];
                uie_pkg::REG_LANE:    r_lane    <= pwdata[1:0];
                uie_pkg::REG_NOM_10G: r_nom10   <= pwdata;
                uie_pkg::REG_NOM_25G: r_nom25   <= pwdata;
                uie_pkg::REG_SPEED25: r_speed25 <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            uie_pkg::REG_ADJUST:  prdata = {31'd0, r_adjust};
            uie_pkg::REG_FEC:     prdata = {30'd0, r_fec};
            uie_pkg::REG_LANE:    prdata = {30'd0, r_lane};
            uie_pkg::REG_NOM_10G: prdata = r_nom10;
            uie_pkg::REG_NOM_25G: prdata = r_nom25;
            uie_pkg::REG_SPEED25: prdata = {31'd0, r_speed25};
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // Stage k loads when it is empty or its content moves on.
    logic [NSt-1:0] r_vld;
    logic [NSt:0]   w_en;
    logic [NSt-1:0] w_vin;

    always_comb begin
        w_en[NSt] = i_ready;
        for (int k = NSt - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_vin   = {r_vld[NSt-2:0], i_valid};
    assign o_ready = w_en[0];
    assign o_valid = r_vld[OutS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSt; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // ---------------- stage 1: deltas, interval and nominal select -------
    logic [uie_pkg::SpanW-1:0] w_tx_span, w_rx_span;
    logic [uie_pkg::CntW-1:0]  w_tx_cnt, w_rx_cnt;
    logic [uie_pkg::IvlW-1:0]  w_tx_ivl, w_rx_ivl;
    logic [31:0]               w_nom;
    uie_pkg::t_ctl             w_ctl1;

    uie_span u_span_tx (
        .i_time_first (i_tx_time_first),
        .i_time_later (i_tx_time_later),
        .i_count_first(i_tx_count_first),
        .i_count_later(i_tx_count_later),
        .o_span       (w_tx_span),
        .o_cnt        (w_tx_cnt)
    );

    uie_span u_span_rx (
        .i_time_first (i_rx_time_first),
        .i_time_later (i_rx_time_later),
        .i_count_first(i_rx_count_first),
        .i_count_later(i_rx_count_later),
        .o_span       (w_rx_span),
        .o_cnt        (w_rx_cnt)
    );

    always_comb begin
        unique case (r_fec)
            uie_pkg::FEC_KR: begin
                w_tx_ivl = uie_pkg::IVL_LONG;
                w_rx_ivl = uie_pkg::IVL_LONG;
            end
            uie_pkg::FEC_NONE: begin
                w_tx_ivl = uie_pkg::IVL_LONG;
                w_rx_ivl = uie_pkg::IVL_SHORT;
            end
            default: begin
                w_tx_ivl = '0;
                w_rx_ivl = '0;
            end
        endcase
        unique case (r_lane)
            uie_pkg::LANE_10G: w_nom = r_nom10;
            uie_pkg::LANE_25G: w_nom = r_nom25;
            default:           w_nom = 32'd0;
        endcase
        // Early outcomes decided before any arithmetic.
        priority if (!r_adjust) begin
            w_ctl1 = '{done: 1'b1, code: uie_pkg::ST_DISABLED};
        end else if (i_too_slow) begin
            w_ctl1 = '{done: 1'b1, code: uie_pkg::ST_TOO_SLOW};
        end else begin
            w_ctl1 = '{done: 1'b0, code: uie_pkg::ST_OK};
        end
    end

    logic [uie_pkg::SpanW-1:0] r1_tx_span, r1_rx_span;
    logic [uie_pkg::CntW-1:0]  r1_tx_cnt, r1_rx_cnt;
    logic [uie_pkg::IvlW-1:0]  r1_tx_ivl, r1_rx_ivl;
    logic [uie_pkg::NomW-1:0]  r1_nom8;
    logic                      r1_chk_tx, r1_chk_rx;
    uie_pkg::t_ctl             r1_ctl;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_tx_span <= w_tx_span;
            r1_rx_span <= w_rx_span;
            r1_tx_cnt  <= w_tx_cnt;
            r1_rx_cnt  <= w_rx_cnt;
            r1_tx_ivl  <= w_tx_ivl;
            r1_rx_ivl  <= w_rx_ivl;
            r1_nom8    <= w_nom[31:8];
            // estimate check only applies with a nominal and an interval
            r1_chk_tx  <= (w_nom != 32'd0) && (w_tx_ivl != '0);
            r1_chk_rx  <= (w_nom != 32'd0) && (w_rx_ivl != '0);
            r1_ctl     <= w_ctl1;
        end
    end

    // ---------------- stage 2: divisor and estimate products ----------
    logic [uie_pkg::SpanW-1:0] r2_tx_span, r2_rx_span;
    logic [uie_pkg::DenW-1:0]  r2_tx_den, r2_rx_den;
    logic [uie_pkg::EstW-1:0]  r2_tx_est, r2_rx_est;
    logic                      r2_chk_tx, r2_chk_rx;
    uie_pkg::t_ctl             r2_ctl;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_tx_span <= r1_tx_span;
            r2_rx_span <= r1_rx_span;
            r2_tx_den  <= r1_tx_cnt * r1_tx_ivl;
            r2_rx_den  <= r1_rx_cnt * r1_rx_ivl;
            r2_tx_est  <= r1_tx_ivl * r1_nom8;
            r2_rx_est  <= r1_rx_ivl * r1_nom8;
            r2_chk_tx  <= r1_chk_tx;
            r2_chk_rx  <= r1_chk_rx;
            r2_ctl     <= r1_ctl;
        end
    end

    // ---------------- stage 3: estimate limit ----------------
    // span / est > 64000 holds exactly when span >= 64001 * est.
    logic [uie_pkg::SpanW-1:0] r3_tx_span, r3_rx_span;
    logic [uie_pkg::DenW-1:0]  r3_tx_den, r3_rx_den;
    logic [uie_pkg::LimW-1:0]  r3_tx_lim, r3_rx_lim;
    logic                      r3_chk_tx, r3_chk_rx;
    uie_pkg::t_ctl             r3_ctl;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_tx_span <= r2_tx_span;
            r3_rx_span <= r2_rx_span;
            r3_tx_den  <= r2_tx_den;
            r3_rx_den  <= r2_rx_den;
            r3_tx_lim  <= r2_tx_est * uie_pkg::EST_MUL;
            r3_rx_lim  <= r2_rx_est * uie_pkg::EST_MUL;
            r3_chk_tx  <= r2_chk_tx;
            r3_chk_rx  <= r2_chk_rx;
            r3_ctl     <= r2_ctl;
        end
    end

    // ---------------- stage 4: estimate compare, divider setup --------
    uie_pkg::t_ctl w_ctl4;
    logic          w_tx_bad, w_rx_bad;

    assign w_tx_bad = r3_chk_tx && (r3_tx_span >= {1'b0, r3_tx_lim});
    assign w_rx_bad = r3_chk_rx && (r3_rx_span >= {1'b0, r3_rx_lim});

    always_comb begin
        priority if (r3_ctl.done) begin
            w_ctl4 = r3_ctl;
        end else if (w_tx_bad) begin
            w_ctl4 = '{done: 1'b1, code: uie_pkg::ST_TX_EST};
        end else if (w_rx_bad) begin
            w_ctl4 = '{done: 1'b1, code: uie_pkg::ST_RX_EST};
        end else begin
            w_ctl4 = r3_ctl;
        end
    end

    uie_pkg::t_div r4_tx, r4_rx;
    uie_pkg::t_ctl r4_ctl;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_tx  <= '{rem: {r3_tx_span, 8'd0}, den: r3_tx_den, quo: '0};
            r4_rx  <= '{rem: {r3_rx_span, 8'd0}, den: r3_rx_den, quo: '0};
            r4_ctl <= w_ctl4;
        end
    end

    // ---------------- divider stages ----------------
    // Only 21 quotient bits are formed; a larger true quotient comes out
    // as all ones, which lies outside both windows, as does a zero divisor.
    uie_pkg::t_div r_dtx [DivN];
    uie_pkg::t_div r_drx [DivN];
    uie_pkg::t_ctl r_dctl[DivN];

    for (genvar j = 0; j < DivN; j++) begin : g_div
        localparam int unsigned First = uie_pkg::DivSteps - 1 - j * uie_pkg::StepsPerStage;
        localparam int unsigned Steps = (First + 1 < uie_pkg::StepsPerStage) ?
                                        First + 1 : uie_pkg::StepsPerStage;
        uie_pkg::t_div w_tx_in, w_rx_in, w_tx_out, w_rx_out;
        uie_pkg::t_ctl w_ctl_in;

        if (j == 0) begin : g_first
            assign w_tx_in  = r4_tx;
            assign w_rx_in  = r4_rx;
            assign w_ctl_in = r4_ctl;
        end else begin : g_next
            assign w_tx_in  = r_dtx[j-1];
            assign w_rx_in  = r_drx[j-1];
            assign w_ctl_in = r_dctl[j-1];
        end

        uie_div_stage #(.FIRST_STEP(First), .NUM_STEPS(Steps)) u_tx (
            .i_d(w_tx_in),
            .o_d(w_tx_out)
        );
        uie_div_stage #(.FIRST_STEP(First), .NUM_STEPS(Steps)) u_rx (
            .i_d(w_rx_in),
            .o_d(w_rx_out)
        );

        always_ff @(posedge i_clk) begin
            if (w_en[4 + j]) begin
                r_dtx[j]  <= w_tx_out;
                r_drx[j]  <= w_rx_out;
                r_dctl[j] <= w_ctl_in;
            end
        end
    end

    // ---------------- output stage: window check ----------------
    logic [uie_pkg::UiW-1:0] w_tx_q, w_rx_q, w_lo, w_hi;
    logic                    w_tx_ok, w_rx_ok;
    uie_pkg::t_ctl           w_fin;

    assign w_tx_q  = r_dtx[DivN-1].quo;
    assign w_rx_q  = r_drx[DivN-1].quo;
    assign w_lo    = r_speed25 ? uie_pkg::WIN25_LO : uie_pkg::WIN10_LO;
    assign w_hi    = r_speed25 ? uie_pkg::WIN25_HI : uie_pkg::WIN10_HI;
    assign w_tx_ok = (w_tx_q >= w_lo) && (w_tx_q <= w_hi);
    assign w_rx_ok = (w_rx_q >= w_lo) && (w_rx_q <= w_hi);

    always_comb begin
        priority if (r_dctl[DivN-1].done) begin
            w_fin = r_dctl[DivN-1];
        end else if (!w_tx_ok) begin
            w_fin = '{done: 1'b1, code: uie_pkg::ST_TX_WIN};
        end else if (!w_rx_ok) begin
            w_fin = '{done: 1'b1, code: uie_pkg::ST_RX_WIN};
        end else begin
            w_fin = '{done: 1'b0, code: uie_pkg::ST_OK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[OutS]) begin
            o_status           <= w_fin.code;
            o_write_values     <= !w_fin.done;
            o_tx_unit_interval <= w_fin.done ? '0 : w_tx_q;
            o_rx_unit_interval <= w_fin.done ? '0 : w_rx_q;
        end
    end

endmodule
`default_nettype wire
